[design/skf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, codes and types for the rate and position fusion block.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int MAX_RANGES    = 1024;
    localparam int CNT_W         = $clog2(MAX_RANGES + 1);
    localparam int SUM_W         = 32 + $clog2(MAX_RANGES);

    // input commands
    localparam logic [1:0] CMD_GYRO  = 2'd0;
    localparam logic [1:0] CMD_ODO   = 2'd1;
    localparam logic [1:0] CMD_LIDAR = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MOTION_VAR = 3'd0;
    localparam logic [2:0] REG_GYRO_VAR   = 3'd1;
    localparam logic [2:0] REG_LIDAR_VAR  = 3'd2;
    localparam logic [2:0] REG_COLL_THR   = 3'd3;
    localparam logic [2:0] REG_RANGE_FLR  = 3'd4;
    localparam logic [2:0] REG_RANGE_CEIL = 3'd5;

    // result kinds
    localparam logic EVT_FUSED = 1'b0;
    localparam logic EVT_RELOC = 1'b1;

    // whole number to fixed point, saturating
    function automatic logic [31:0] fx_whole(input logic [31:0] units);
        logic [63:0] v;
        v = {32'd0, units} << FRACTION_BITS;
        return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    localparam logic [31:0] RST_MOTION_VAR = fx_whole(32'd4);
    localparam logic [31:0] RST_GYRO_VAR   = 32'((64'd1 << FRACTION_BITS) >> 1);
    localparam logic [31:0] RST_LIDAR_VAR  = fx_whole(32'd2);
    localparam logic [31:0] RST_COLL_THR   = fx_whole(32'd100);
    localparam logic [31:0] RST_EST_VAR    = fx_whole(32'd1000);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GYRO,
        S_ODO,
        S_LIDAR,
        S_LWAIT,
        S_FK,
        S_FKW,
        S_FKM,
        S_FKC,
        S_FVD,
        S_FVW,
        S_OUT
    } t_state;

endpackage

[design/skf_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_in_if
// Input item channel: sensor command and its measurement fields.
// ----------------------------------------------------------------------------
interface skf_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  command;
    logic signed [31:0] rate;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic        [31:0] range;
    logic               range_last;

    modport source (output valid, command, rate, accel_x, accel_y, accel_z, range,
                    range_last, input ready);
    modport sink (input valid, command, rate, accel_x, accel_y, accel_z, range,
                  range_last, output ready);
endinterface

[design/skf_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_out_if
// Result item channel: event kind with current estimates and variances.
// ----------------------------------------------------------------------------
interface skf_out_if;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic signed [31:0] fused_rate;
    logic        [31:0] fused_position;
    logic        [31:0] rate_variance_out;
    logic        [31:0] position_variance_out;

    modport source (output valid, event_kind, fused_rate, fused_position,
                    rate_variance_out, position_variance_out, input ready);
    modport sink (input valid, event_kind, fused_rate, fused_position,
                  rate_variance_out, position_variance_out, output ready);
endinterface

[design/skf_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_mul
// Shared unsigned 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module skf_mul import skf_pkg::*; (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [63:0] o_prod
);

    logic [65:0] n_prod;
    logic [63:0] r_prod;

    // all products used fit 64 bits
    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod[63:0];
    end

    assign o_prod = r_prod;

endmodule

[design/skf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider, one quotient bit per cycle, 32 bits of quotient.
// The upper numerator half must be below the divisor.
// ----------------------------------------------------------------------------
module skf_div import skf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [32:0] r_rem, n_rem;
    logic [31:0] r_low, n_low;
    logic [32:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_low[31]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[32:0] : trial[32:0];
        n_low = {r_low[30:0], ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[63:32]};
            r_low <= i_num[31:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

[design/scalar_kalman_rate_position_fusion_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_rate_position_fusion_top
// Rate and position scalar Kalman filters on one shared multiplier and one
// shared divider, run by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        content
//  i_in      in   valid / ready    command, rate, accel, range, range_last
//  o_out     out  valid / ready    event kind, estimates, variances
//  i_cfg_*   in   write enable     register index, 32-bit data
//
//  per item: gyro sums the squared accelerations, plus a relocalize result
//  over threshold; lidar divides for the average on a scan's last reading if
//  any was valid; odometry runs up to four 32-step divisions (two per filter).
//  i_in.ready is high only while the sequencer is idle; a finished result
//  waits in the output register, so a stalled o_out holds the sequencer
//  only when a second result is due. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module scalar_kalman_rate_position_fusion_top import skf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skf_in_if.sink      i_in,
    skf_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_motion_var, r_gyro_var, r_lidar_var, r_coll_thr;
    logic [31:0] r_range_flr, r_range_ceil;

    // filter state
    logic signed [31:0] r_rate_est, n_rate_est;
    logic [31:0]        r_rate_var, n_rate_var;
    logic [31:0]        r_pos_est, n_pos_est;
    logic [31:0]        r_pos_var, n_pos_var;
    logic signed [31:0] r_gyro_held, n_gyro_held;
    logic signed [31:0] r_prev_odo, n_prev_odo;
    logic               r_await, n_await;
    logic [31:0]        r_lidar_avg, n_lidar_avg;
    logic [SUM_W-1:0]   r_range_sum, n_range_sum;
    logic [CNT_W-1:0]   r_range_cnt, n_range_cnt;

    // item and work registers
    logic signed [31:0] r_rate, r_ax, r_ay, r_az;
    logic [31:0]        r_range;
    logic               r_last;
    logic [2:0]         r_cnt, n_cnt;
    logic [63:0]        r_acc, n_acc;
    logic [31:0]        r_k, n_k;
    logic               r_pass, n_pass;
    logic               r_kind, n_kind;

    // output register
    logic               r_ov;
    logic               r_o_kind;
    logic signed [31:0] r_o_rate;
    logic [31:0]        r_o_pos, r_o_rvar, r_o_pvar;

    // shared units
    logic [32:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        div_start, div_done;
    logic [63:0] div_num;
    logic [32:0] div_den;
    logic [31:0] quot;

    // fusion operands of the current pass
    logic [31:0]        f_p, f_r;
    logic signed [33:0] f_x, f_z, f_diff, f_new;
    logic [32:0]        f_den, f_mag, f_corr;
    logic [63:0]        f_rnd;

    // prediction and lidar helpers
    logic signed [32:0] motion;
    logic signed [33:0] pred;
    logic [32:0]        var_sum;
    logic               rng_ok;
    logic [SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   acc_cnt;

    logic               in_acc;
    logic               out_free;
    logic [32:0]        mag_x, mag_y, mag_z;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    skf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // acceleration magnitudes
    always_comb begin
        mag_x = r_ax[31] ? 33'(-{1'b1, r_ax}) : {1'b0, r_ax};
        mag_y = r_ay[31] ? 33'(-{1'b1, r_ay}) : {1'b0, r_ay};
        mag_z = r_az[31] ? 33'(-{1'b1, r_az}) : {1'b0, r_az};
    end

    // operand selection for the current fusion pass
    always_comb begin
        f_p    = r_pass ? r_pos_var : r_rate_var;
        f_r    = r_pass ? r_lidar_var : r_gyro_var;
        f_x    = r_pass ? {2'b00, r_pos_est} : {{2{r_rate_est[31]}}, r_rate_est};
        f_z    = r_pass ? {2'b00, r_lidar_avg} : {{2{r_gyro_held[31]}}, r_gyro_held};
        f_den  = {1'b0, f_p} + {1'b0, f_r};
        f_diff = f_z - f_x;
        f_mag  = f_diff[33] ? 33'(-f_diff) : f_diff[32:0];
        f_rnd  = prod + 64'h4000_0000;
        f_corr = f_rnd[63:31];
        f_new  = f_diff[33] ? f_x - {1'b0, f_corr} : f_x + {1'b0, f_corr};
    end

    // prediction and range window
    always_comb begin
        motion  = {r_rate[31], r_rate} - {r_prev_odo[31], r_prev_odo};
        pred    = {{2{r_rate_est[31]}}, r_rate_est} + {motion[32], motion};
        var_sum = {1'b0, r_rate_var} + {1'b0, r_motion_var};
        rng_ok  = (r_range >= r_range_flr) && (r_range <= r_range_ceil)
                  && (r_range_cnt < CNT_W'(MAX_RANGES));
        acc_sum = rng_ok ? r_range_sum + SUM_W'(r_range) : r_range_sum;
        acc_cnt = rng_ok ? r_range_cnt + CNT_W'(1) : r_range_cnt;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.command)
                        CMD_GYRO:  n_state = S_GYRO;
                        CMD_ODO:   n_state = S_ODO;
                        CMD_LIDAR: n_state = S_LIDAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_GYRO: begin
                if (r_cnt == 3'd4) begin
                    n_state = (r_acc > prod) ? S_OUT : S_IDLE;
                end
            end
            S_ODO:   n_state = r_await ? S_IDLE : S_FK;
            S_LIDAR: n_state = (r_last && acc_cnt != '0) ? S_LWAIT : S_IDLE;
            S_LWAIT: n_state = div_done ? S_IDLE : S_LWAIT;
            S_FK: begin
                if (f_den == '0) begin
                    n_state = r_pass ? S_OUT : S_FK;
                end else begin
                    n_state = S_FKW;
                end
            end
            S_FKW:   n_state = div_done ? S_FKM : S_FKW;
            S_FKM:   n_state = S_FKC;
            S_FKC:   n_state = S_FVD;
            S_FVD:   n_state = S_FVW;
            S_FVW: begin
                if (div_done) begin
                    n_state = r_pass ? S_OUT : S_FK;
                end
            end
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (r_state)
            S_GYRO: begin
                case (r_cnt)
                    3'd0:    begin mul_a = mag_x; mul_b = mag_x; end
                    3'd1:    begin mul_a = mag_y; mul_b = mag_y; end
                    3'd2:    begin mul_a = mag_z; mul_b = mag_z; end
                    default: begin
                        mul_a = {1'b0, r_coll_thr};
                        mul_b = {1'b0, r_coll_thr};
                    end
                endcase
            end
            S_LIDAR: begin
                div_start = r_last && (acc_cnt != '0);
                div_num   = {{(64 - SUM_W){1'b0}}, acc_sum};
                div_den   = {{(33 - CNT_W){1'b0}}, acc_cnt};
            end
            S_FK: begin
                div_start = (f_den != '0);
                div_num   = {1'b0, f_p, 31'd0};
                div_den   = f_den;
            end
            S_FKM: begin
                mul_a = {1'b0, r_k};
                mul_b = f_mag;
            end
            S_FKC: begin
                mul_a = {1'b0, f_p};
                mul_b = {1'b0, f_r};
            end
            S_FVD: begin
                div_start = 1'b1;
                div_num   = prod + {32'd0, f_den[32:1]};
                div_den   = f_den;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_rate_est  = r_rate_est;
        n_rate_var  = r_rate_var;
        n_pos_est   = r_pos_est;
        n_pos_var   = r_pos_var;
        n_gyro_held = r_gyro_held;
        n_prev_odo  = r_prev_odo;
        n_await     = r_await;
        n_lidar_avg = r_lidar_avg;
        n_range_sum = r_range_sum;
        n_range_cnt = r_range_cnt;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_k         = r_k;
        n_pass      = r_pass;
        n_kind      = r_kind;
        unique case (r_state)
            S_IDLE: begin
                n_cnt  = '0;
                n_acc  = '0;
                n_pass = 1'b0;
                if (in_acc && i_in.command == CMD_GYRO) begin
                    n_gyro_held = i_in.rate;
                end
            end
            S_GYRO: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt != 3'd0 && r_cnt != 3'd4) begin
                    n_acc = r_acc + prod;
                end
                n_kind = EVT_RELOC;
            end
            S_ODO: begin
                n_prev_odo = r_rate;
                n_kind     = EVT_FUSED;
                if (r_await) begin
                    n_rate_est = r_rate;
                    n_await    = 1'b0;
                end else begin
                    if (pred[33:31] == 3'b000 || pred[33:31] == 3'b111) begin
                        n_rate_est = pred[31:0];
                    end else begin
                        n_rate_est = pred[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    n_rate_var = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
                end
            end
            S_LIDAR: begin
                n_range_sum = acc_sum;
                n_range_cnt = acc_cnt;
                if (r_last) begin
                    n_range_sum = '0;
                    n_range_cnt = '0;
                end
            end
            S_LWAIT: begin
                if (div_done) begin
                    n_lidar_avg = quot;
                end
            end
            S_FK: begin
                // zero total variance keeps the estimate
                if (f_den == '0) begin
                    n_pass = 1'b1;
                    if (r_pass) begin
                        n_pos_var = '0;
                    end else begin
                        n_rate_var = '0;
                    end
                end
            end
            S_FKW: begin
                if (div_done) begin
                    n_k = quot;
                end
            end
            S_FKC: begin
                if (r_pass) begin
                    n_pos_est = f_new[31:0];
                end else begin
                    n_rate_est = f_new[31:0];
                end
            end
            S_FVW: begin
                if (div_done) begin
                    n_pass = 1'b1;
                    if (r_pass) begin
                        n_pos_var = quot;
                    end else begin
                        n_rate_var = quot;
                    end
                end
            end
            default: begin
                n_pass = r_pass;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate_est  <= '0;
            r_rate_var  <= RST_EST_VAR;
            r_pos_est   <= '0;
            r_pos_var   <= RST_EST_VAR;
            r_gyro_held <= '0;
            r_prev_odo  <= '0;
            r_await     <= 1'b1;
            r_lidar_avg <= '0;
            r_range_sum <= '0;
            r_range_cnt <= '0;
            r_pass      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rate_est  <= n_rate_est;
            r_rate_var  <= n_rate_var;
            r_pos_est   <= n_pos_est;
            r_pos_var   <= n_pos_var;
            r_gyro_held <= n_gyro_held;
            r_prev_odo  <= n_prev_odo;
            r_await     <= n_await;
            r_lidar_avg <= n_lidar_avg;
            r_range_sum <= n_range_sum;
            r_range_cnt <= n_range_cnt;
            r_pass      <= n_pass;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_var <= RST_MOTION_VAR;
            r_gyro_var   <= RST_GYRO_VAR;
            r_lidar_var  <= RST_LIDAR_VAR;
            r_coll_thr   <= RST_COLL_THR;
            r_range_flr  <= '0;
            r_range_ceil <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MOTION_VAR: r_motion_var <= i_cfg_data;
                REG_GYRO_VAR:   r_gyro_var   <= i_cfg_data;
                REG_LIDAR_VAR:  r_lidar_var  <= i_cfg_data;
                REG_COLL_THR:   r_coll_thr   <= i_cfg_data;
                REG_RANGE_FLR:  r_range_flr  <= i_cfg_data;
                REG_RANGE_CEIL: r_range_ceil <= i_cfg_data;
                default:        r_range_ceil <= r_range_ceil;
            endcase
        end
    end

    // item latch, work registers and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rate  <= i_in.rate;
            r_ax    <= i_in.accel_x;
            r_ay    <= i_in.accel_y;
            r_az    <= i_in.accel_z;
            r_range <= i_in.range;
            r_last  <= i_in.range_last;
        end
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_k    <= n_k;
        r_kind <= n_kind;
        if (r_state == S_OUT && out_free) begin
            r_o_kind <= r_kind;
            r_o_rate <= r_rate_est;
            r_o_pos  <= r_pos_est;
            r_o_rvar <= r_rate_var;
            r_o_pvar <= r_pos_var;
        end
    end

    assign o_out.valid                 = r_ov;
    assign o_out.event_kind            = r_o_kind;
    assign o_out.fused_rate            = r_o_rate;
    assign o_out.fused_position        = r_o_pos;
    assign o_out.rate_variance_out     = r_o_rvar;
    assign o_out.position_variance_out = r_o_pvar;

    // divider finishes only where the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_FKW || r_state == S_FVW || r_state == S_LWAIT))
        else $error("divider finished outside a wait state");

    // scan count stays within the per-scan limit
    a_range_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range_cnt <= CNT_W'(MAX_RANGES))
        else $error("range count beyond scan limit");

    // once seeded, the rate filter never waits for a first odometry item again
    a_seed_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_await |=> !r_await)
        else $error("first odometry flag set again");

    // a result leaving the sequencer shows up on the output
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_out.valid)
        else $error("result not presented");

endmodule
